/* hdl/msbr_pkg.sv */
// Shared constants and types for the msb-first bit reader
`default_nettype none

package msbr_pkg;

    // default size of the byte store
    localparam int STORE_BYTES_DEF = 4096;

    // field widths of one input and one result transaction
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int SEEK_W     = 16;
    localparam int SKIP_W     = 13;
    localparam int VALUE_W    = 64;
    localparam int LEFT_W     = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;

    // longest field that one read may return
    localparam logic [COUNT_W-1:0] MAX_READ_BITS = 7'd64;

    // accumulator holds up to nine fetched bytes
    localparam int ACC_W = 72;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_READ   = 3'd2,
        CMD_SEEK   = 3'd3,
        CMD_SKIP   = 3'd4
    } cmd_t;

    // read sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_ALIGN  = 5'b00100,
        S_EXTEND = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* hdl/msb_first_bit_reader.sv */
// Top level of the msb-first bit reader: command decode, byte store and read sequencer
//
// channel  dir  handshake          tdata fields (low bit first)
// s        in   s_tvalid/s_tready  command, byte_value, bit_count, sign_extend,
//                                  seek_target, skip_count
// m        out  m_tvalid/m_tready  read_value, ok, bits_left, bytes_skipped
//
// Append, clear, seek, skip and rejected reads show their result the cycle after
// acceptance, one transaction per cycle. A good read fetches nbytes, the 1 to 9
// stored bytes the field touches, one per cycle through the single byte-wide read
// port of the store, then aligns and extends; the result register is loaded once it
// is free, and the next transaction is taken only after that.
// Reset clears fill length, position and the sequencer; store contents stay.
// A new transaction is taken only when idle and the result register is free,
// so a stalled result stalls the input side.
`default_nettype none

module msb_first_bit_reader
    import msbr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // command[2:0], byte_value[10:3], bit_count[17:11], sign_extend[18],
    // seek_target[34:19], skip_count[47:35]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // read_value[63:0], ok[64], bits_left[80:65], bytes_skipped[93:81], zero[95:94]
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int FILL_W = $clog2(STORE_BYTES + 1);
    localparam int POS_W  = FILL_W + 3;
    localparam int CMP_W  = (POS_W > SEEK_W) ? POS_W : SEEK_W;
    localparam int SK_W   = (FILL_W > SKIP_W) ? FILL_W : SKIP_W;

    // input fields
    cmd_t               in_cmd;
    logic [BYTE_W-1:0]  in_byte;
    logic [COUNT_W-1:0] in_count;
    logic               in_sext;
    logic [SEEK_W-1:0]  in_seek;
    logic [SKIP_W-1:0]  in_skip;

    // architectural state
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    // sequencer
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [3:0]         issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [2:0]         drop_reg, drop_next;
    logic               sext_reg, sext_next;
    logic [VALUE_W-1:0] field_reg, field_next;
    logic [LEFT_W-1:0]  left_reg, left_next;

    // result register
    logic               mvalid_reg, mvalid_next;
    logic [VALUE_W-1:0] ovalue_reg, ovalue_next;
    logic               ook_reg, ook_next;
    logic [LEFT_W-1:0]  oleft_reg, oleft_next;
    logic [SKIP_W-1:0]  oskip_reg, oskip_next;

    // working signals
    logic               in_fire;
    logic               out_free;
    logic               out_load;
    logic [POS_W-1:0]   total;
    logic [POS_W-1:0]   rem_now;
    logic               read_ok;
    logic [7:0]         span_sum;
    logic [2:0]         off_bits;
    logic [CMP_W-1:0]   seek_ext;
    logic [CMP_W-1:0]   total_ext;
    logic [SK_W-1:0]    skip_ext;
    logic [SK_W-1:0]    avail_ext;
    logic [SK_W-1:0]    skipped;
    logic [POS_W-1:0]   left_full;
    logic [CMP_W-1:0]   left_ext;
    logic [LEFT_W-1:0]  left_now;
    logic [VALUE_W-1:0] field_mask;
    logic [ACC_W-1:0]   acc_shift;
    logic [5:0]         top_idx;

    // byte store port signals
    logic               ram_we;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata;

    assign in_cmd   = cmd_t'(s_tdata[2:0]);
    assign in_byte  = s_tdata[10:3];
    assign in_count = s_tdata[17:11];
    assign in_sext  = s_tdata[18];
    assign in_seek  = s_tdata[34:19];
    assign in_skip  = s_tdata[47:35];

    // handshake
    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, oskip_reg, oleft_reg, ook_reg, ovalue_reg};

    // position bookkeeping
    assign total     = {fill_reg, 3'b000};
    assign rem_now   = total - pos_reg;
    assign read_ok   = (in_count != '0) && (in_count <= MAX_READ_BITS)
                       && (POS_W'(in_count) <= rem_now);
    assign off_bits  = pos_reg[2:0];
    assign span_sum  = 8'(off_bits) + 8'(in_count) + 8'd7;
    assign seek_ext  = CMP_W'(in_seek);
    assign total_ext = CMP_W'(total);
    assign skip_ext  = SK_W'(in_skip);
    assign avail_ext = SK_W'(rem_now[POS_W-1:3]);
    assign skipped   = (skip_ext < avail_ext) ? skip_ext : avail_ext;
    assign left_full = {fill_next, 3'b000} - pos_next;
    assign left_ext  = CMP_W'(left_full);
    assign left_now  = left_ext[LEFT_W-1:0];

    // field alignment helpers
    assign field_mask = ~({VALUE_W{1'b1}} << n_reg);
    assign acc_shift  = acc_reg >> drop_reg;
    assign top_idx    = 6'(n_reg - 7'd1);

    always_comb
    begin
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        state_next  = state_reg;
        addr_next   = addr_reg;
        issue_next  = issue_reg;
        pend_next   = 1'b0;
        acc_next    = acc_reg;
        n_next      = n_reg;
        drop_next   = drop_reg;
        sext_next   = sext_reg;
        field_next  = field_reg;
        left_next   = left_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        out_load    = 1'b0;
        ovalue_next = ovalue_reg;
        ook_next    = ook_reg;
        oleft_next  = oleft_reg;
        oskip_next  = oskip_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_load    = 1'b1;
                    ovalue_next = '0;
                    ook_next    = 1'b0;
                    oskip_next  = '0;
                    case (in_cmd)
                        CMD_APPEND:
                        begin
                            if (fill_reg < FILL_W'(STORE_BYTES))
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                                ook_next  = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            pos_next  = '0;
                            ook_next  = 1'b1;
                        end
                        CMD_READ:
                        begin
                            if (read_ok)
                            begin
                                out_load   = 1'b0;
                                pos_next   = pos_reg + POS_W'(in_count);
                                state_next = S_FETCH;
                                addr_next  = pos_reg[ADDR_W+2:3];
                                issue_next = span_sum[6:3];
                                n_next     = in_count;
                                drop_next  = 3'd0 - (off_bits + in_count[2:0]);
                                sext_next  = in_sext;
                            end
                        end
                        CMD_SEEK:
                        begin
                            pos_next = (seek_ext < total_ext) ? seek_ext[POS_W-1:0]
                                                              : total;
                            ook_next = 1'b1;
                        end
                        CMD_SKIP:
                        begin
                            if (off_bits == 3'd0)
                            begin
                                pos_next   = pos_reg + {skipped[FILL_W-1:0], 3'b000};
                                ook_next   = 1'b1;
                                oskip_next = skipped[SKIP_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    oleft_next = left_now;
                    left_next  = left_now;
                end
            end
            // one byte address per cycle; the registered read data is taken while pend_reg is set
            S_FETCH:
            begin
                if (issue_reg != 4'd0)
                begin
                    ram_re     = 1'b1;
                    addr_next  = addr_reg + ADDR_W'(1);
                    issue_next = issue_reg - 4'd1;
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = {acc_reg[ACC_W-BYTE_W-1:0], ram_rdata};
                end
                if ((issue_reg == 4'd0) && !pend_reg)
                begin
                    state_next = S_ALIGN;
                end
            end
            // drop trailing bits and mask to the field width
            S_ALIGN:
            begin
                field_next = acc_shift[VALUE_W-1:0] & field_mask;
                state_next = S_EXTEND;
            end
            // sign extension of short fields
            S_EXTEND:
            begin
                if (sext_reg && (n_reg != MAX_READ_BITS) && field_reg[top_idx])
                begin
                    field_next = field_reg | ~field_mask;
                end
                state_next = S_DONE;
            end
            // wait for the result register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    ovalue_next = field_reg;
                    ook_next    = 1'b1;
                    oleft_next  = left_reg;
                    oskip_next  = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (out_load)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        else
        begin
            mvalid_next = mvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            pos_reg    <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        acc_reg    <= acc_next;
        n_reg      <= n_next;
        drop_reg   <= drop_next;
        sext_reg   <= sext_next;
        field_reg  <= field_next;
        left_reg   <= left_next;
        ovalue_reg <= ovalue_next;
        ook_reg    <= ook_next;
        oleft_reg  <= oleft_next;
        oskip_reg  <= oskip_next;
    end

    // byte store
    msbr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* hdl/msbr_ram.sv */
// Generic single-clock RAM with one write port and a registered read port
`default_nettype none

module msbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
